// File: hdl/psd_pkg.sv
// Shared types, constants and step functions for the point to segment distance block.
package psd_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_END_X   = 3'd3,
		REG_END_Y   = 3'd4,
		REG_END_Z   = 3'd5,
		REG_TOL     = 3'd6
	} reg_idx_t;

	localparam logic [31:0] START_RST = 32'd0;
	localparam logic [31:0] END_X_RST = 32'd65536;
	localparam logic [31:0] END_YZ_RST = 32'd0;
	localparam logic [31:0] TOL_RST   = 32'd1;

	// Cross product operand axes: c[i] = d[j]*v[k] - d[k]*v[j]
	localparam int AX_J [3] = '{1, 2, 0};
	localparam int AX_K [3] = '{2, 0, 1};

	// Pipeline geometry
	localparam int ROOT_STEPS = 33;   // one root bit per stage, 66-bit radicand
	localparam int DIV_STEPS  = 66;   // one quotient bit per stage
	localparam int ST_DS      = 3 + ROOT_STEPS;
	localparam int ST_QUO     = 6 + DIV_STEPS;
	localparam int ST_DA      = ST_QUO + ROOT_STEPS;
	localparam int ST_LEG     = ST_DA + 2 + ROOT_STEPS;
	localparam int PSD_LATENCY = ST_LEG + 2;

	// Square root stage state (restoring, two radicand bits per step)
	typedef struct packed {
		logic [65:0] rad;
		logic [35:0] rem;
		logic [32:0] root;
	} sq_t;

	// Long divider stage state
	typedef struct packed {
		logic [65:0] num;
		logic [66:0] rem;
		logic [65:0] quo;
	} dv_t;

	function automatic logic [31:0] mag33(logic [32:0] x);
		logic [32:0] n;
		n = -x;
		return x[32] ? n[31:0] : x[31:0];
	endfunction

	function automatic sq_t sq_init(logic [65:0] x);
		sq_t r;
		r.rad = x;
		r.rem = '0;
		r.root = '0;
		return r;
	endfunction

	function automatic sq_t sqrt_step(sq_t a);
		sq_t r;
		logic [35:0] t2;
		logic [35:0] trial;
		t2 = {a.rem[33:0], a.rad[65:64]};
		trial = {1'b0, a.root, 2'b01};
		r.rad = {a.rad[63:0], 2'b00};
		if (t2 >= trial) begin
			r.rem = t2 - trial;
			r.root = {a.root[31:0], 1'b1};
		end else begin
			r.rem = t2;
			r.root = {a.root[31:0], 1'b0};
		end
		return r;
	endfunction

	// Quotient of a 132-bit dividend known to be below divisor * 2^66
	function automatic dv_t dv_init(logic [131:0] x);
		dv_t r;
		r.num = x[65:0];
		r.rem = {1'b0, x[131:66]};
		r.quo = '0;
		return r;
	endfunction

	function automatic dv_t div_step(dv_t a, logic [65:0] dv);
		dv_t r;
		logic [66:0] t;
		t = {a.rem[65:0], a.num[65]};
		r.num = {a.num[64:0], 1'b0};
		if (t >= {1'b0, dv}) begin
			r.rem = t - {1'b0, dv};
			r.quo = {a.quo[64:0], 1'b1};
		end else begin
			r.rem = t;
			r.quo = {a.quo[64:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: hdl/point_segment_distance_3d.sv
// Top level: pipelined point to 3D segment distance, line parameter and on-line flag.
//
// Usage:
//   Configure the segment start, end and tolerance through wr_en/wr_index/wr_data
//   while no point is in flight; a write lands at the clock edge where wr_en is high.
//   A point transfer happens at a rising edge with start high and busy low. busy
//   stays low: the pipeline takes one point every cycle, back to back.
//   Each result appears on seg_distance, line_position and on_line for exactly one
//   cycle with done high, in point order. Throughput is one point per cycle; the
//   result path is the chain of the cross product, the 66-step quotient
//   |c|^2/|v|^2, and two 33-step square roots in a row (axis distance, then the
//   projection legs), one bit per stage.
//   The line parameter runs in a parallel branch of per-axis dividers and is
//   delayed to line up with the distance.
//   The receiver cannot hold results off, so nothing ever stalls.
//   Reset clears all valid bits and loads the default segment (0,0,0)-(65536,0,0),
//   tolerance 1; points in flight at reset are dropped.
module point_segment_distance_3d
	import psd_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic        done,
	output logic [32:0] seg_distance,
	output logic signed [31:0] line_position,
	output logic        on_line
);

	localparam int NQ    = 32 + FRAC_BITS;    // per-axis ratio quotient bits
	localparam int SW    = NQ + 2;            // ratio sum magnitude bits
	localparam int NS    = (SW + 7) / 8;      // averaging stages, 8 bits each
	localparam int SWP   = NS * 8;
	localparam int LS    = NQ + 2;            // sum stage
	localparam int LP_ST = LS + NS + 1;       // saturated line parameter stage

	typedef struct packed {
		logic [NQ-1:0] num;
		logic [32:0]   rem;
		logic [NQ-1:0] quo;
		logic          neg;
	} ld_t;

	typedef struct packed {
		logic [SWP-1:0] num;
		logic [1:0]     rem;
		logic [SWP-1:0] quo;
		logic           neg;
	} cd_t;

	function automatic ld_t ld_step(ld_t a, logic [31:0] dv);
		ld_t r;
		logic [32:0] t;
		t = {a.rem[31:0], a.num[NQ-1]};
		r.neg = a.neg;
		r.num = {a.num[NQ-2:0], 1'b0};
		if (t >= {1'b0, dv}) begin
			r.rem = t - {1'b0, dv};
			r.quo = {a.quo[NQ-2:0], 1'b1};
		end else begin
			r.rem = t;
			r.quo = {a.quo[NQ-2:0], 1'b0};
		end
		return r;
	endfunction

	// Eight quotient bits of a division by the axis count (0 to 3, 0 only for a degenerate segment)
	function automatic cd_t cd_step8(cd_t a, logic [1:0] dv);
		cd_t r;
		logic [2:0] t;
		r = a;
		for (int k = 0; k < 8; k++) begin
			t = {r.rem, r.num[SWP-1]};
			r.num = {r.num[SWP-2:0], 1'b0};
			if (t >= {1'b0, dv}) begin
				t = t - {1'b0, dv};
				r.quo = {r.quo[SWP-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[SWP-2:0], 1'b0};
			end
			r.rem = t[1:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] sat32(cd_t a);
		logic [SWP-1:0] n;
		n = -a.quo;
		if (!a.neg)
			return (a.quo > SWP'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : a.quo[31:0];
		else
			return (a.quo > SWP'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : n[31:0];
	endfunction

	// Configuration registers
	logic [31:0] cfg_q [7];
	logic [31:0] cfg_n [7];

	// Next configuration, so a point taken with a write sees the new value
	always_comb begin
		for (int i = 0; i < 7; i++)
			cfg_n[i] = cfg_q[i];
		if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_START_X: cfg_n[0] = wr_data;
				REG_START_Y: cfg_n[1] = wr_data;
				REG_START_Z: cfg_n[2] = wr_data;
				REG_END_X:   cfg_n[3] = wr_data;
				REG_END_Y:   cfg_n[4] = wr_data;
				REG_END_Z:   cfg_n[5] = wr_data;
				REG_TOL:     cfg_n[6] = wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= START_RST;
			cfg_q[1] <= START_RST;
			cfg_q[2] <= START_RST;
			cfg_q[3] <= END_X_RST;
			cfg_q[4] <= END_YZ_RST;
			cfg_q[5] <= END_YZ_RST;
			cfg_q[6] <= TOL_RST;
		end else begin
			for (int i = 0; i < 7; i++)
				cfg_q[i] <= cfg_n[i];
		end
	end

	// Segment direction terms; the user must keep them constant while points are in flight, the block does not enforce it
	logic [31:0] vm_c [3];
	logic [2:0]  vn_c;
	logic [2:0]  vnz_c;
	logic [1:0]  cnt_c;
	logic        degen_c;

	always_comb begin
		logic [32:0] v;
		for (int i = 0; i < 3; i++) begin
			v = {cfg_q[i+3][31], cfg_q[i+3]} - {cfg_q[i][31], cfg_q[i]};
			vm_c[i] = mag33(v);
			vn_c[i] = v[32];
			vnz_c[i] = (v != '0);
		end
		cnt_c = 2'($countones(vnz_c));
		degen_c = (vnz_c == '0);
	end

	// Transfer and valid line
	logic                 take;
	logic [PSD_LATENCY:1] vld_s;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[PSD_LATENCY-1:1], take};
	end

	// Stage 1: differences to start, to end, and the direction
	logic [31:0] pt_c [3];
	logic [31:0] dm_s1 [3];
	logic [31:0] qm_s1 [3];
	logic [31:0] vm_s1 [3];
	logic [2:0]  dn_s1, vn_s1;

	assign pt_c[0] = point_x;
	assign pt_c[1] = point_y;
	assign pt_c[2] = point_z;

	always_ff @(posedge clk) begin
		logic [32:0] d, q, v;
		for (int i = 0; i < 3; i++) begin
			d = {pt_c[i][31], pt_c[i]} - {cfg_n[i][31], cfg_n[i]};
			q = {pt_c[i][31], pt_c[i]} - {cfg_n[i+3][31], cfg_n[i+3]};
			v = {cfg_n[i+3][31], cfg_n[i+3]} - {cfg_n[i][31], cfg_n[i]};
			dm_s1[i] <= mag33(d);
			qm_s1[i] <= mag33(q);
			vm_s1[i] <= mag33(v);
			dn_s1[i] <= d[32];
			vn_s1[i] <= v[32];
		end
	end

	// Stage 2: squares and cross product terms
	logic [63:0] dd_s2 [3], qq_s2 [3], vv_s2 [3], pa_s2 [3], pb_s2 [3];
	logic [2:0]  sa_s2, sb_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dd_s2[i] <= 64'(dm_s1[i]) * 64'(dm_s1[i]);
			qq_s2[i] <= 64'(qm_s1[i]) * 64'(qm_s1[i]);
			vv_s2[i] <= 64'(vm_s1[i]) * 64'(vm_s1[i]);
			pa_s2[i] <= 64'(dm_s1[AX_J[i]]) * 64'(vm_s1[AX_K[i]]);
			pb_s2[i] <= 64'(dm_s1[AX_K[i]]) * 64'(vm_s1[AX_J[i]]);
			sa_s2[i] <= dn_s1[AX_J[i]] ^ vn_s1[AX_K[i]];
			sb_s2[i] <= dn_s1[AX_K[i]] ^ vn_s1[AX_J[i]];
		end
	end

	// Stage 3: squared lengths and cross product magnitudes
	logic [65:0] d2_s3, q2_s3, v2_s3;
	logic [64:0] cm_s3 [3];

	always_ff @(posedge clk) begin
		logic [65:0] a, b, c, cn;
		d2_s3 <= 66'(dd_s2[0]) + 66'(dd_s2[1]) + 66'(dd_s2[2]);
		q2_s3 <= 66'(qq_s2[0]) + 66'(qq_s2[1]) + 66'(qq_s2[2]);
		v2_s3 <= 66'(vv_s2[0]) + 66'(vv_s2[1]) + 66'(vv_s2[2]);
		for (int i = 0; i < 3; i++) begin
			a = sa_s2[i] ? -{2'b00, pa_s2[i]} : {2'b00, pa_s2[i]};
			b = sb_s2[i] ? -{2'b00, pb_s2[i]} : {2'b00, pb_s2[i]};
			c = a - b;
			cn = -c;
			cm_s3[i] <= c[65] ? cn[64:0] : c[64:0];
		end
	end

	// Stage 4: partial products of each cross component squared
	logic [65:0] hh_s4 [3];
	logic [64:0] hl_s4 [3];
	logic [63:0] ll_s4 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s4[i] <= 66'(cm_s3[i][64:32]) * 66'(cm_s3[i][64:32]);
			hl_s4[i] <= 65'(cm_s3[i][64:32]) * 65'(cm_s3[i][31:0]);
			ll_s4[i] <= 64'(cm_s3[i][31:0]) * 64'(cm_s3[i][31:0]);
		end
	end

	// Stage 5: component squares; stage 6: |c|^2
	logic [129:0] csq_s5 [3];
	logic [131:0] c2_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			csq_s5[i] <= {hh_s4[i], 64'b0} + 130'({hl_s4[i], 33'b0}) + 130'(ll_s4[i]);
		c2_s6 <= 132'(csq_s5[0]) + 132'(csq_s5[1]) + 132'(csq_s5[2]);
	end

	// |c|^2 / |v|^2, one quotient bit per stage
	dv_t bd_s [DIV_STEPS];

	always_ff @(posedge clk) begin
		bd_s[0] <= div_step(dv_init(c2_s6), v2_s3);
		for (int k = 1; k < DIV_STEPS; k++)
			bd_s[k] <= div_step(bd_s[k-1], v2_s3);
	end

	// Square roots: axis distance, endpoint distances, segment length
	sq_t sq_da [ROOT_STEPS];
	sq_t sq_ds [ROOT_STEPS];
	sq_t sq_de [ROOT_STEPS];
	sq_t sq_sg [ROOT_STEPS];

	always_ff @(posedge clk) begin
		sq_da[0] <= sqrt_step(sq_init(bd_s[DIV_STEPS-1].quo));
		sq_ds[0] <= sqrt_step(sq_init(d2_s3));
		sq_de[0] <= sqrt_step(sq_init(q2_s3));
		sq_sg[0] <= sqrt_step(sq_init(v2_s3));
		for (int k = 1; k < ROOT_STEPS; k++) begin
			sq_da[k] <= sqrt_step(sq_da[k-1]);
			sq_ds[k] <= sqrt_step(sq_ds[k-1]);
			sq_de[k] <= sqrt_step(sq_de[k-1]);
			sq_sg[k] <= sqrt_step(sq_sg[k-1]);
		end
	end

	// Endpoint distances and axis distance wait for the legs
	logic [32:0] ds_dl [ST_DS+1:ST_LEG];
	logic [32:0] de_dl [ST_DS+1:ST_LEG];
	logic [32:0] da_dl [ST_DA+1:ST_LEG];

	always_ff @(posedge clk) begin
		ds_dl[ST_DS+1] <= sq_ds[ROOT_STEPS-1].root;
		de_dl[ST_DS+1] <= sq_de[ROOT_STEPS-1].root;
		for (int k = ST_DS + 2; k <= ST_LEG; k++) begin
			ds_dl[k] <= ds_dl[k-1];
			de_dl[k] <= de_dl[k-1];
		end
		da_dl[ST_DA+1] <= sq_da[ROOT_STEPS-1].root;
		for (int k = ST_DA + 2; k <= ST_LEG; k++)
			da_dl[k] <= da_dl[k-1];
	end

	// Leg radicands: squares, then clamped differences
	logic [65:0] ssq_s106, esq_s106, asq_s106;
	logic        sgt_s106, egt_s106;
	logic [65:0] rs_s107, re_s107;

	always_ff @(posedge clk) begin
		ssq_s106 <= 66'(ds_dl[ST_DA]) * 66'(ds_dl[ST_DA]);
		esq_s106 <= 66'(de_dl[ST_DA]) * 66'(de_dl[ST_DA]);
		asq_s106 <= 66'(sq_da[ROOT_STEPS-1].root) * 66'(sq_da[ROOT_STEPS-1].root);
		sgt_s106 <= ds_dl[ST_DA] > sq_da[ROOT_STEPS-1].root;
		egt_s106 <= de_dl[ST_DA] > sq_da[ROOT_STEPS-1].root;
		rs_s107 <= sgt_s106 ? ssq_s106 - asq_s106 : '0;
		re_s107 <= egt_s106 ? esq_s106 - asq_s106 : '0;
	end

	sq_t sq_ls [ROOT_STEPS];
	sq_t sq_le [ROOT_STEPS];

	always_ff @(posedge clk) begin
		sq_ls[0] <= sqrt_step(sq_init(rs_s107));
		sq_le[0] <= sqrt_step(sq_init(re_s107));
		for (int k = 1; k < ROOT_STEPS; k++) begin
			sq_ls[k] <= sqrt_step(sq_ls[k-1]);
			sq_le[k] <= sqrt_step(sq_le[k-1]);
		end
	end

	// Per-axis ratios (P-S)_i / v_i, one quotient bit per stage
	ld_t ld_s [3][NQ];

	always_ff @(posedge clk) begin
		ld_t init;
		for (int i = 0; i < 3; i++) begin
			init.num = {dm_s1[i], FRAC_BITS'(0)};
			init.rem = '0;
			init.quo = '0;
			init.neg = dn_s1[i] ^ vn_c[i];
			ld_s[i][0] <= ld_step(init, vm_c[i]);
			for (int k = 1; k < NQ; k++)
				ld_s[i][k] <= ld_step(ld_s[i][k-1], vm_c[i]);
		end
	end

	// Signed sum of the ratios, then divide by the axis count
	cd_t cdi_s;
	cd_t cd_s [NS];
	logic [31:0] lp_dl [LP_ST:ST_LEG+1];

	always_ff @(posedge clk) begin
		logic signed [NQ+2:0] acc;
		logic signed [NQ+2:0] r;
		logic [NQ+2:0] am;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			r = $signed({3'b000, ld_s[i][NQ-1].quo});
			if (vnz_c[i])
				acc = ld_s[i][NQ-1].neg ? acc - r : acc + r;
		end
		am = acc[NQ+2] ? -acc : acc;
		cdi_s.num <= SWP'(am[SW-1:0]);
		cdi_s.rem <= '0;
		cdi_s.quo <= '0;
		cdi_s.neg <= acc[NQ+2];
		cd_s[0] <= cd_step8(cdi_s, cnt_c);
		for (int k = 1; k < NS; k++)
			cd_s[k] <= cd_step8(cd_s[k-1], cnt_c);
		lp_dl[LP_ST] <= sat32(cd_s[NS-1]);
		for (int k = LP_ST + 1; k <= ST_LEG + 1; k++)
			lp_dl[k] <= lp_dl[k-1];
	end

	// Pick the distance: axis, nearer endpoint, or start point when degenerate
	logic [32:0] dist_s141;
	logic [32:0] dist_s142;
	logic [31:0] lp_s142;
	logic        on_s142;

	always_ff @(posedge clk) begin
		logic [33:0] legs;
		logic [32:0] near;
		legs = 34'(sq_ls[ROOT_STEPS-1].root) + 34'(sq_le[ROOT_STEPS-1].root);
		near = (ds_dl[ST_LEG] < de_dl[ST_LEG]) ? ds_dl[ST_LEG] : de_dl[ST_LEG];
		if (degen_c)
			dist_s141 <= ds_dl[ST_LEG];
		else if (legs > {1'b0, sq_sg[ROOT_STEPS-1].root})
			dist_s141 <= near;
		else
			dist_s141 <= da_dl[ST_LEG];
		dist_s142 <= dist_s141;
		on_s142 <= !degen_c && (dist_s141 <= {1'b0, cfg_q[6]});
		lp_s142 <= degen_c ? '0 : lp_dl[ST_LEG+1];
	end

	assign done          = vld_s[PSD_LATENCY];
	assign seg_distance  = dist_s142;
	assign line_position = lp_s142;
	assign on_line       = on_s142;

endmodule

// File: hdl/psd_checker.sv
// Port-level checker for the point to segment distance block, bound to the top level.
module psd_checker
	import psd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [32:0] seg_distance,
	input logic [31:0] line_position,
	input logic        on_line
);

	// Every point transfer yields a result with done high
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PSD_LATENCY done)
		else $error("point transfer without result");

	// No result without a matching point transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PSD_LATENCY))
		else $error("result without point transfer");

	// Zero distance with a nonzero line position is always on the line
	a_zero_on_line: assert property (@(posedge clk) disable iff (!arst_n)
		(done && seg_distance == '0 && line_position != '0) |-> on_line)
		else $error("zero distance not flagged on line");

endmodule

bind point_segment_distance_3d psd_checker u_psd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.seg_distance(seg_distance),
	.line_position(line_position),
	.on_line(on_line)
);
